### design/bmm_pkg.sv
`default_nettype none

package bmm_pkg;

    // Widths fixed by the element and index fields of the channels.
    localparam int IdxWidth  = 3;
    localparam int WordWidth = 32;

    typedef logic [IdxWidth-1:0]         t_idx;
    typedef logic signed [WordWidth-1:0] t_word;

    // Sequencer states: loading, tiled multiply-accumulate, and readout.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_C_RD,
        ST_AB_RD,
        ST_MUL,
        ST_ADD,
        ST_C_WR,
        ST_DR_RD,
        ST_DR_OUT
    } t_bmm_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_wr;
        logic c_rd;
        logic ab_rd;
        logic acc_init;
        logic acc_zero;
        logic mul_en;
        logic acc_add;
        logic c_wr;
        logic out_load;
        logic out_last;
    } t_bmm_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_bmm_stat;

endpackage

`default_nettype wire

### design/bmm_load_if.sv
`default_nettype none

interface bmm_load_if;
    import bmm_pkg::*;

    logic  valid;
    logic  ready;
    t_idx  row_index;
    t_idx  col_index;
    t_word a_elem;
    t_word b_elem;
    logic  load_done;

    modport source (
        output valid, row_index, col_index, a_elem, b_elem, load_done,
        input  ready
    );

    modport sink (
        input  valid, row_index, col_index, a_elem, b_elem, load_done,
        output ready
    );

endinterface

`default_nettype wire

### design/bmm_result_if.sv
`default_nettype none

interface bmm_result_if;
    import bmm_pkg::*;

    logic  valid;
    logic  ready;
    t_idx  out_row;
    t_idx  out_col;
    t_word c_elem;
    logic  last_out;

    modport source (
        output valid, out_row, out_col, c_elem, last_out,
        input  ready
    );

    modport sink (
        input  valid, out_row, out_col, c_elem, last_out,
        output ready
    );

endinterface

`default_nettype wire

### design/bmm_ctrl.sv
`default_nettype none

module bmm_ctrl #(
    parameter int MATRIX_DIM = 8,
    parameter int TILE_DIM   = 2
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_load_valid,
    input  wire                          i_load_done,
    output logic                         o_load_ready,
    input  bmm_pkg::t_bmm_stat           i_stat,
    output bmm_pkg::t_bmm_cmd            o_cmd,
    output logic [$clog2(MATRIX_DIM)-1:0] o_i,
    output logic [$clog2(MATRIX_DIM)-1:0] o_j,
    output logic [$clog2(MATRIX_DIM)-1:0] o_k
);
    import bmm_pkg::*;

    localparam int IW   = $clog2(MATRIX_DIM);
    localparam int CW   = IW + 4;
    localparam int Step = (TILE_DIM > 0) ? TILE_DIM : 1;

    localparam logic [CW-1:0] StepC   = CW'(Step);
    localparam logic [CW-1:0] DimC    = CW'(MATRIX_DIM);
    localparam logic [IW-1:0] LastIdx = IW'(MATRIX_DIM - 1);

    t_bmm_state    r_state, n_state;
    logic [IW-1:0] r_ti, n_ti, r_tj, n_tj, r_tk, n_tk;
    logic [IW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;

    logic load_acc;
    logic last_i, last_j, last_k;
    logic last_ti, last_tj, last_tk;
    logic last_elem;

    // True when x is the final index of the span that starts at t.
    function automatic logic span_last(input logic [IW-1:0] x, input logic [IW-1:0] t);
        logic [CW-1:0] span_end;
        span_end  = CW'(t) + StepC - CW'(1);
        span_last = (x == LastIdx) || (CW'(x) == span_end);
    endfunction

    // True when the tile that starts at t is the final one along its axis.
    function automatic logic tile_last(input logic [IW-1:0] t);
        tile_last = (CW'(t) + StepC) >= DimC;
    endfunction

    assign load_acc  = i_load_valid && o_load_ready;
    assign last_i    = span_last(r_i, r_ti);
    assign last_j    = span_last(r_j, r_tj);
    assign last_k    = span_last(r_k, r_tk);
    assign last_ti   = tile_last(r_ti);
    assign last_tj   = tile_last(r_tj);
    assign last_tk   = tile_last(r_tk);
    assign last_elem = (r_i == LastIdx) && (r_j == LastIdx);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (load_acc && i_load_done) begin
                    n_state = ST_C_RD;
                end
            end
            ST_C_RD:  n_state = ST_AB_RD;
            ST_AB_RD: n_state = ST_MUL;
            ST_MUL:   n_state = ST_ADD;
            ST_ADD: begin
                n_state = last_k ? ST_C_WR : ST_AB_RD;
            end
            ST_C_WR: begin
                if (last_j && last_i && last_tk && last_tj && last_ti) begin
                    n_state = ST_DR_RD;
                end else begin
                    n_state = ST_C_RD;
                end
            end
            ST_DR_RD: n_state = ST_DR_OUT;
            ST_DR_OUT: begin
                if (i_stat.out_free) begin
                    n_state = last_elem ? ST_IDLE : ST_DR_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Loop counters: tiles outermost, then rows and columns inside a tile.
    always_comb begin
        n_ti = r_ti;
        n_tj = r_tj;
        n_tk = r_tk;
        n_i  = r_i;
        n_j  = r_j;
        n_k  = r_k;
        case (r_state)
            ST_ADD: begin
                if (!last_k) begin
                    n_k = r_k + IW'(1);
                end
            end
            ST_C_WR: begin
                if (last_j && last_i) begin
                    if (!last_tk) begin
                        n_tk = IW'(CW'(r_tk) + StepC);
                    end else begin
                        n_tk = '0;
                        if (!last_tj) begin
                            n_tj = IW'(CW'(r_tj) + StepC);
                        end else begin
                            n_tj = '0;
                            if (!last_ti) begin
                                n_ti = IW'(CW'(r_ti) + StepC);
                            end else begin
                                n_ti = '0;
                            end
                        end
                    end
                end
                if (!last_j) begin
                    n_j = r_j + IW'(1);
                end else begin
                    n_j = n_tj;
                    if (!last_i) begin
                        n_i = r_i + IW'(1);
                    end else begin
                        n_i = n_ti;
                    end
                end
                n_k = n_tk;
            end
            ST_DR_OUT: begin
                if (i_stat.out_free) begin
                    if (r_j != LastIdx) begin
                        n_j = r_j + IW'(1);
                    end else begin
                        n_j = '0;
                        n_i = last_elem ? '0 : r_i + IW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Commands to the datapath; no request is taken while reset is held.
    always_comb begin
        o_cmd          = '0;
        o_load_ready   = (r_state == ST_IDLE) && i_rst_n;
        o_cmd.load_wr  = load_acc;
        case (r_state)
            ST_C_RD:  o_cmd.c_rd = 1'b1;
            ST_AB_RD: begin
                o_cmd.ab_rd    = 1'b1;
                o_cmd.acc_init = (r_k == r_tk);
                o_cmd.acc_zero = (r_tk == '0);
            end
            ST_MUL:   o_cmd.mul_en  = 1'b1;
            ST_ADD:   o_cmd.acc_add = 1'b1;
            ST_C_WR:  o_cmd.c_wr    = 1'b1;
            ST_DR_RD: o_cmd.c_rd    = 1'b1;
            ST_DR_OUT: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_last = last_elem;
            end
            default: begin
            end
        endcase
    end

    assign o_i = r_i;
    assign o_j = r_j;
    assign o_k = r_k;

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ti    <= '0;
            r_tj    <= '0;
            r_tk    <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_ti    <= n_ti;
            r_tj    <= n_tj;
            r_tk    <= n_tk;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

endmodule

`default_nettype wire

### design/bmm_datapath.sv
`default_nettype none

module bmm_datapath #(
    parameter int MATRIX_DIM = 8
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  bmm_pkg::t_bmm_cmd             i_cmd,
    output bmm_pkg::t_bmm_stat            o_stat,
    input  wire [$clog2(MATRIX_DIM)-1:0]  i_i,
    input  wire [$clog2(MATRIX_DIM)-1:0]  i_j,
    input  wire [$clog2(MATRIX_DIM)-1:0]  i_k,
    input  bmm_pkg::t_idx                 i_load_row,
    input  bmm_pkg::t_idx                 i_load_col,
    input  bmm_pkg::t_word                i_load_a,
    input  bmm_pkg::t_word                i_load_b,
    bmm_result_if.source                  o_result
);
    import bmm_pkg::*;

    localparam int IW    = $clog2(MATRIX_DIM);
    localparam int AW    = 2 * IW;
    localparam int Depth = 2 ** AW;

    t_word r_a_store [Depth];
    t_word r_b_store [Depth];
    t_word r_c_store [Depth];

    t_word r_a_rd, r_b_rd, r_c_rd;
    t_word r_prod, r_acc;

    logic          r_out_valid;
    t_idx          r_out_row, r_out_col;
    t_word         r_out_elem;
    logic          r_out_last;

    logic          load_ok;
    logic [AW-1:0] load_addr, a_addr, b_addr, c_addr;

    // Pairs outside the matrix are dropped.
    assign load_ok   = (int'(i_load_row) < MATRIX_DIM) && (int'(i_load_col) < MATRIX_DIM);
    assign load_addr = {i_load_row[IW-1:0], i_load_col[IW-1:0]};
    assign a_addr    = {i_i, i_k};
    assign b_addr    = {i_k, i_j};
    assign c_addr    = {i_i, i_j};

    // A store: written by loads, read by the multiply loop.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && load_ok) begin
            r_a_store[load_addr] <= i_load_a;
        end
        if (i_cmd.ab_rd) begin
            r_a_rd <= r_a_store[a_addr];
        end
    end

    // B store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && load_ok) begin
            r_b_store[load_addr] <= i_load_b;
        end
        if (i_cmd.ab_rd) begin
            r_b_rd <= r_b_store[b_addr];
        end
    end

    // C store: partial sums per tile pass, then read out row by row.
    always_ff @(posedge i_clk) begin
        if (i_cmd.c_wr) begin
            r_c_store[c_addr] <= r_acc;
        end
        if (i_cmd.c_rd) begin
            r_c_rd <= r_c_store[c_addr];
        end
    end

    // Multiply and accumulate; only the low 32 bits are kept.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= WordWidth'(r_a_rd * r_b_rd);
        end
        if (i_cmd.acc_init) begin
            r_acc <= i_cmd.acc_zero ? '0 : r_c_rd;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_row  <= t_idx'(i_i);
            r_out_col  <= t_idx'(i_j);
            r_out_elem <= r_c_rd;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_stat.out_free  = !r_out_valid || o_result.ready;
    assign o_result.valid    = r_out_valid;
    assign o_result.out_row  = r_out_row;
    assign o_result.out_col  = r_out_col;
    assign o_result.c_elem   = r_out_elem;
    assign o_result.last_out = r_out_last;

endmodule

`default_nettype wire

### design/block_matrix_multiply.sv
`default_nettype none

// Blocked signed integer matrix multiplier. Each load request writes one element of A and one
// of B at (row_index, col_index), one request per cycle; pairs outside MATRIX_DIM are dropped.
// The request with load_done set is stored and then starts C = A*B, computed over
// TILE_DIM x TILE_DIM tiles with 32-bit wrapping sums, after which C is sent in row-major
// order with last_out on the final element. Loads are refused from load_done until the last
// result has been handed to the output register. A product uses the single shared
// multiply-accumulate (read A and B, multiply, add) and reads and writes back partial sums per
// tile pass, then sends each result through the C memory read port; output stalls hold the
// readout.
module block_matrix_multiply #(
    parameter int MATRIX_DIM = 8,
    parameter int TILE_DIM   = 2
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    bmm_load_if.sink      i_load,
    bmm_result_if.source  o_result
);
    import bmm_pkg::*;

    localparam int IW = $clog2(MATRIX_DIM);

    t_bmm_cmd      cmd;
    t_bmm_stat     stat;
    logic [IW-1:0] idx_i, idx_j, idx_k;

    // Sequencer for loading, tiled accumulation and readout.
    bmm_ctrl #(
        .MATRIX_DIM (MATRIX_DIM),
        .TILE_DIM   (TILE_DIM)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (i_load.valid),
        .i_load_done  (i_load.load_done),
        .o_load_ready (i_load.ready),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_i          (idx_i),
        .o_j          (idx_j),
        .o_k          (idx_k)
    );

    // Matrix stores, multiply-accumulate and output register.
    bmm_datapath #(
        .MATRIX_DIM (MATRIX_DIM)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_i        (idx_i),
        .i_j        (idx_j),
        .i_k        (idx_k),
        .i_load_row (i_load.row_index),
        .i_load_col (i_load.col_index),
        .i_load_a   (i_load.a_elem),
        .i_load_b   (i_load.b_elem),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire
